// File: sv/bbg_pkg.sv
// Shared types, constants and helper functions of the battery bar gauge.
// Used by every module of the gauge; depends on nothing else.
`default_nettype none

package bbg_pkg;

  localparam int unsigned ADC_BITS_DEF = 12;
  localparam int unsigned SENSE_W      = 12;
  localparam int unsigned MV_W         = 14;
  localparam int unsigned CAL_W        = 17;
  localparam int unsigned REF_W        = 13;
  localparam int unsigned TS_W         = 32;
  localparam int unsigned BARS_W       = 3;
  localparam int unsigned PCT_W        = 7;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 17;
  localparam int unsigned DIV_STEPS    = MV_W;
  localparam int unsigned INIT_BL_W    = 13;

  localparam logic [REF_W-1:0] REF_TIMES_DIV_MV = 13'd6600;
  localparam logic [MV_W-1:0]  MV_MAX           = 14'd16383;
  localparam logic [MV_W-1:0]  DEFAULT_BASE_MV  = 14'd4000;
  localparam logic [MV_W-1:0]  INIT_BL_MIN      = 14'd2000;
  localparam logic [MV_W-1:0]  INIT_BL_MAX      = 14'd5000;
  localparam logic [PCT_W-1:0] PCT_FULL         = 7'd100;
  localparam logic [BARS_W-1:0] BARS_TOP        = 3'd4;
  localparam logic [BARS_W-1:0] BARS_RESET      = 3'd1;

  localparam logic [CAL_W-1:0] CAL_RST      = 17'd67502;
  localparam logic [11:0]      DETECT_RST   = 12'd1000;
  localparam logic [9:0]       OFFSET_RST   = 10'd200;
  localparam logic [MV_W-1:0]  FULL_RST     = 14'd4125;
  localparam logic [MV_W-1:0]  LOW_RST      = 14'd3300;
  localparam logic [15:0]      INTERVAL_RST = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_BL  = 3'd6;

  typedef struct packed {
    logic [CAL_W-1:0]   calibration_q16;
    logic [SENSE_W-1:0] charge_detect_level;
    logic [9:0]         charge_offset_mv;
    logic [MV_W-1:0]    full_charge_mv;
    logic [MV_W-1:0]    low_battery_mv;
    logic [15:0]        animation_interval_ms;
  } bbg_cfg_t;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic            charging;
    logic [TS_W-1:0] now_ms;
  } bbg_item_t;

  function automatic logic [BARS_W-1:0] bars_of(input logic [MV_W-1:0] mv);
    logic [BARS_W-1:0] b;
    if (mv > 14'd3900)      b = 3'd4;
    else if (mv > 14'd3600) b = 3'd3;
    else if (mv > 14'd3300) b = 3'd2;
    else if (mv > 14'd3000) b = 3'd1;
    else                    b = 3'd0;
    return b;
  endfunction

  function automatic logic [PCT_W-1:0] pct_of(input logic [BARS_W-1:0] bars);
    logic [PCT_W-1:0] p;
    case (bars)
      3'd0: p = 7'd0;
      3'd1: p = 7'd25;
      3'd2: p = 7'd50;
      3'd3: p = 7'd75;
      3'd4: p = 7'd100;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: sv/bbg_front.sv
// Front end of the gauge: accepts samples, scales the battery code to
// calibrated millivolts (shift-and-add quotient estimate, one correction step)
// and flags charging. Depends on bbg_pkg.
`default_nettype none

module bbg_front import bbg_pkg::*; #(
  parameter int unsigned AdcBits = ADC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bbg_cfg_t           cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [AdcBits-1:0] battery_code_i,
  input  wire logic [SENSE_W-1:0] sense_code_i,
  input  wire logic [TS_W-1:0]    now_ms_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output bbg_item_t               item_o
);

  localparam int unsigned MULA_W = AdcBits + REF_W;
  localparam int unsigned PROD_W = MULA_W + CAL_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned T_W    = SUM_W - 16;
  localparam int unsigned EST_W  = T_W + 1;
  localparam logic [AdcBits-1:0] DIV_D   = AdcBits'((1 << AdcBits) - 1);
  localparam logic [SUM_W-1:0]   BIAS    = SUM_W'(DIV_D) << 15;
  localparam logic [T_W-1:0]     SAT_LIM = T_W'(DIV_D) << DIV_STEPS;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_MULA = 7'b0000010,
    F_MULB = 7'b0000100,
    F_NORM = 7'b0001000,
    F_EST  = 7'b0010000,
    F_DIV  = 7'b0100000,
    F_PUSH = 7'b1000000
  } front_state_e;

  front_state_e        state_q, state_d;
  logic [AdcBits-1:0]  code_q;
  logic                charging_q;
  logic [TS_W-1:0]     now_q;
  logic [MULA_W-1:0]   mula_q;
  logic [PROD_W-1:0]   prod_q;
  logic [T_W-1:0]      t_q;
  logic [MV_W-1:0]     quo_q;
  logic                sat_q;
  logic [SUM_W-1:0]    sum;
  logic [T_W-1:0]      t_val;
  logic [EST_W-1:0]    est;
  logic [T_W-1:0]      rem;
  logic                ge;
  logic                accept;

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = (state_q == F_PUSH) && !full_i;

  assign item_o.mv       = sat_q ? MV_MAX : quo_q;
  assign item_o.charging = charging_q;
  assign item_o.now_ms   = now_q;

  assign sum   = SUM_W'(prod_q) + BIAS;
  assign t_val = sum[SUM_W-1:16];
  assign est   = EST_W'(t_q) + EST_W'(t_q >> AdcBits) + EST_W'(t_q >> (2 * AdcBits));
  assign rem   = t_q - (T_W'(quo_q) << AdcBits) + T_W'(quo_q);
  assign ge    = rem >= T_W'(DIV_D);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_MULA;
      F_MULA: state_d = F_MULB;
      F_MULB: state_d = F_NORM;
      F_NORM: state_d = F_EST;
      F_EST:  state_d = F_DIV;
      F_DIV:  state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q     <= battery_code_i;
      charging_q <= sense_code_i > cfg_i.charge_detect_level;
      now_q      <= now_ms_i;
    end
    if (state_q == F_MULA) mula_q <= MULA_W'(code_q) * MULA_W'(REF_TIMES_DIV_MV);
    if (state_q == F_MULB) prod_q <= PROD_W'(mula_q) * PROD_W'(cfg_i.calibration_q16);
    if (state_q == F_NORM) begin
      sat_q <= t_val >= SAT_LIM;
      t_q   <= t_val;
    end
    if (state_q == F_EST) begin
      quo_q <= est[AdcBits +: MV_W];
    end else if (state_q == F_DIV) begin
      quo_q <= quo_q + {{(MV_W-1){1'b0}}, ge};
    end
  end

endmodule

`default_nettype wire

// File: sv/bbg_fifo.sv
// Two-entry queue that carries converted samples from front to back end.
// Depends on bbg_pkg for the entry type.
`default_nettype none

module bbg_fifo import bbg_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire bbg_item_t item_i,
  input  wire logic      pop_i,
  output bbg_item_t      item_o,
  output logic           full_o,
  output logic           empty_o
);

  bbg_item_t  slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

// File: sv/bbg_back.sv
// Back end of the gauge: baseline tracking, charge animation and result
// register. Depends on bbg_pkg.
`default_nettype none

module bbg_back import bbg_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bbg_cfg_t        cfg_i,
  input  wire logic            bl_load_i,
  input  wire logic [MV_W-1:0] bl_value_i,
  input  wire bbg_item_t       item_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [PCT_W-1:0]     percent_o,
  output logic                 low_battery_o,
  output logic                 save_baseline_o,
  output logic [MV_W-1:0]      baseline_out_mv_o
);

  logic [MV_W-1:0]   baseline_q, bl_e;
  logic              was_charging_q;
  logic              fully_charged_q, full_e;
  logic [MV_W-1:0]   peak_q, peak_e;
  logic [BARS_W-1:0] base_q, base_e;
  logic [BARS_W-1:0] shown_q, shown_e;
  logic [TS_W-1:0]   last_q, last_e;
  logic [MV_W-1:0]   comp;
  logic [MV_W-1:0]   chk;
  logic [BARS_W-1:0] nb;
  logic [TS_W-1:0]   elapsed;
  logic [PCT_W-1:0]  pct;
  logic              save;
  logic              out_valid_q;
  logic [PCT_W-1:0]  pct_q;
  logic              low_q, save_q;

  assign pop_o             = !empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o       = out_valid_q;
  assign percent_o         = pct_q;
  assign low_battery_o     = low_q;
  assign save_baseline_o   = save_q;
  assign baseline_out_mv_o = baseline_q;

  always_comb begin
    comp    = (item_i.mv > MV_W'(cfg_i.charge_offset_mv))
            ? item_i.mv - MV_W'(cfg_i.charge_offset_mv) : '0;
    bl_e    = baseline_q;
    full_e  = fully_charged_q;
    peak_e  = peak_q;
    base_e  = base_q;
    shown_e = shown_q;
    last_e  = last_q;
    nb      = bars_of(comp);
    elapsed = '0;
    save    = 1'b0;
    pct     = '0;
    chk     = comp;
    if (item_i.charging) begin
      if (!was_charging_q) begin
        peak_e  = comp;
        base_e  = nb;
        shown_e = nb;
        full_e  = comp >= cfg_i.full_charge_mv;
        last_e  = item_i.now_ms;
        bl_e    = comp;
        save    = 1'b1;
      end
      if (comp > bl_e) begin
        bl_e = comp;
        save = 1'b1;
      end
      if (full_e) begin
        pct = PCT_FULL;
      end else begin
        if (comp > peak_e) begin
          peak_e = comp;
          if (nb > base_e) begin
            base_e  = nb;
            shown_e = nb;
          end
        end
        elapsed = item_i.now_ms - last_e;
        if (comp >= cfg_i.full_charge_mv) begin
          full_e = 1'b1;
        end else if (elapsed >= TS_W'(cfg_i.animation_interval_ms)) begin
          last_e  = item_i.now_ms;
          shown_e = shown_e + 3'd1;
          if (shown_e > BARS_TOP) shown_e = base_e;
        end
        pct = pct_of(shown_e);
      end
    end else begin
      if (item_i.mv < bl_e) begin
        bl_e = item_i.mv;
        save = 1'b1;
      end
      if (was_charging_q) full_e = 1'b0;
      pct = pct_of(bars_of(bl_e));
      chk = bl_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q      <= DEFAULT_BASE_MV;
      was_charging_q  <= 1'b0;
      fully_charged_q <= 1'b0;
      peak_q          <= '0;
      base_q          <= BARS_RESET;
      shown_q         <= BARS_RESET;
      last_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (bl_load_i) begin
        baseline_q <= bl_value_i;
      end else if (pop_o) begin
        baseline_q      <= bl_e;
        was_charging_q  <= item_i.charging;
        fully_charged_q <= full_e;
        peak_q          <= peak_e;
        base_q          <= base_e;
        shown_q         <= shown_e;
        last_q          <= last_e;
      end
      if (pop_o)            out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pct_q  <= pct;
      low_q  <= chk < cfg_i.low_battery_mv;
      save_q <= save;
    end
  end

  a_shown_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shown_q <= BARS_TOP) && (shown_q >= base_q))
    else $error("shown bars out of range");

  a_full_needs_charge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fully_charged_q |-> was_charging_q)
    else $error("full flag set while not charging");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("popped sample gave no result");

endmodule

`default_nettype wire

// File: sv/battery_bar_gauge_with_charge_animation_unit.sv
// Battery bar gauge with charge animation: one result per sample. The front
// end accepts a sample, passes it through two multiply stages, a rounding
// stage, a quotient estimate and a correction step (division by
// 2^ADC_BITS-1) and pushes it into the queue; it takes no new sample until
// the push is done, and a full queue holds the front end in its push state.
// The back end turns the queue head into a registered result. A two-entry
// queue and the result register let both sides stall apart.
// Depends on bbg_pkg, bbg_front, bbg_fifo and bbg_back.
`default_nettype none

module battery_bar_gauge_with_charge_animation_unit import bbg_pkg::*; #(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ADC_BITS-1:0]   battery_code_i,
  input  wire logic [SENSE_W-1:0]    sense_code_i,
  input  wire logic [TS_W-1:0]       now_ms_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [PCT_W-1:0]           percent_o,
  output logic                       low_battery_o,
  output logic                       save_baseline_o,
  output logic [MV_W-1:0]            baseline_out_mv_o
);

  bbg_cfg_t        cfg_q;
  logic            cfg_we;
  logic            bl_load;
  logic [MV_W-1:0] init_bl;
  logic [MV_W-1:0] bl_value;
  logic            push, pop, full, empty;
  bbg_item_t       push_item, head_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign bl_load     = cfg_we && (cfg_index_i == CFG_INIT_BL);
  assign init_bl     = MV_W'(cfg_data_i[INIT_BL_W-1:0]);
  assign bl_value    = ((init_bl < INIT_BL_MIN) || (init_bl > INIT_BL_MAX))
                     ? DEFAULT_BASE_MV : init_bl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calibration_q16       <= CAL_RST;
      cfg_q.charge_detect_level   <= DETECT_RST;
      cfg_q.charge_offset_mv      <= OFFSET_RST;
      cfg_q.full_charge_mv        <= FULL_RST;
      cfg_q.low_battery_mv        <= LOW_RST;
      cfg_q.animation_interval_ms <= INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_CAL:      cfg_q.calibration_q16       <= cfg_data_i[CAL_W-1:0];
        CFG_DETECT:   cfg_q.charge_detect_level   <= cfg_data_i[SENSE_W-1:0];
        CFG_OFFSET:   cfg_q.charge_offset_mv      <= cfg_data_i[9:0];
        CFG_FULL:     cfg_q.full_charge_mv        <= cfg_data_i[MV_W-1:0];
        CFG_LOW:      cfg_q.low_battery_mv        <= cfg_data_i[MV_W-1:0];
        CFG_INTERVAL: cfg_q.animation_interval_ms <= cfg_data_i[15:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  bbg_front #(
    .AdcBits(ADC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .battery_code_i(battery_code_i),
    .sense_code_i  (sense_code_i),
    .now_ms_i      (now_ms_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  bbg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .full_o (full),
    .empty_o(empty)
  );

  bbg_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .bl_load_i        (bl_load),
    .bl_value_i       (bl_value),
    .item_i           (head_item),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .percent_o        (percent_o),
    .low_battery_o    (low_battery_o),
    .save_baseline_o  (save_baseline_o),
    .baseline_out_mv_o(baseline_out_mv_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/bbg_gauge_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the battery bar gauge: follows register writes and accepted
// sample beats, predicts each reading and compares it with the output beats.
// Depends on bbg_pkg.

module bbg_gauge_checker import bbg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SENSE_W-1:0]    battery_code_i,
  input  logic [SENSE_W-1:0]    sense_code_i,
  input  logic [TS_W-1:0]       now_ms_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [PCT_W-1:0]      percent_i,
  input  logic                  low_battery_i,
  input  logic                  save_baseline_i,
  input  logic [MV_W-1:0]       baseline_out_mv_i,
  output int unsigned           pending_o,
  output int unsigned           mismatches_o,
  output int unsigned           readings_o
);

  localparam logic [MV_W-1:0] LVL4_MV     = 14'd3900;
  localparam logic [MV_W-1:0] LVL3_MV     = 14'd3600;
  localparam logic [MV_W-1:0] LVL2_MV     = 14'd3300;
  localparam logic [MV_W-1:0] LVL1_MV     = 14'd3000;
  localparam logic [MV_W-1:0] SAT_MV      = 14'd16383;
  localparam logic [MV_W-1:0] FALLBACK_MV = 14'd4000;
  localparam logic [MV_W-1:0] BL_LOW_MV   = 14'd2000;
  localparam logic [MV_W-1:0] BL_HIGH_MV  = 14'd5000;
  localparam logic [INIT_BL_W-1:0] BL_RST = 13'd4000;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic             low_battery;
    logic             save_baseline;
    logic [MV_W-1:0]  baseline_mv;
  } reading_t;

  reading_t expected_readings[$];

  logic [CAL_W-1:0]     cal_q16;
  logic [SENSE_W-1:0]   detect_lvl;
  logic [MV_W-1:0]      offset_mv;
  logic [MV_W-1:0]      full_mv;
  logic [MV_W-1:0]      low_mv;
  logic [TS_W-1:0]      interval_ms;
  logic [INIT_BL_W-1:0] init_bl;

  logic [MV_W-1:0]   baseline;
  logic              was_charging;
  logic              full_flag;
  logic [MV_W-1:0]   peak_mv;
  logic [BARS_W-1:0] base_lvl;
  logic [BARS_W-1:0] shown_lvl;
  logic [TS_W-1:0]   last_step;

  function automatic logic [BARS_W-1:0] bar_level(input logic [MV_W-1:0] mv);
    if (mv > LVL4_MV) return 3'd4;
    if (mv > LVL3_MV) return 3'd3;
    if (mv > LVL2_MV) return 3'd2;
    if (mv > LVL1_MV) return 3'd1;
    return 3'd0;
  endfunction

  function automatic logic [MV_W-1:0] checked_baseline(input logic [INIT_BL_W-1:0] v);
    logic [MV_W-1:0] w;
    w = {1'b0, v};
    return (w < BL_LOW_MV || w > BL_HIGH_MV) ? FALLBACK_MV : w;
  endfunction

  function automatic logic [MV_W-1:0] scale_code(input logic [SENSE_W-1:0] code);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    den = ((64'd1 << ADC_BITS_DEF) - 64'd1) * 64'd65536;
    num = {52'd0, code} * 64'd6600 * {47'd0, cal_q16};
    q = (num + den / 64'd2) / den;
    return (q > {50'd0, SAT_MV}) ? SAT_MV : q[MV_W-1:0];
  endfunction

  function automatic reading_t gauge_step(input logic [SENSE_W-1:0] code,
                                          input logic [SENSE_W-1:0] sense,
                                          input logic [TS_W-1:0] stamp);
    reading_t          r;
    logic [MV_W-1:0]   mv;
    logic [MV_W-1:0]   comp;
    logic [MV_W-1:0]   check_mv;
    logic [BARS_W-1:0] nb;
    logic [BARS_W-1:0] lvl;
    logic              charging;
    mv = scale_code(code);
    charging = sense > detect_lvl;
    r.save_baseline = 1'b0;
    if (charging) begin
      comp = (mv > offset_mv) ? mv - offset_mv : '0;
      if (!was_charging) begin
        peak_mv = comp;
        base_lvl = bar_level(comp);
        shown_lvl = base_lvl;
        full_flag = comp >= full_mv;
        last_step = stamp;
        baseline = comp;
        r.save_baseline = 1'b1;
      end
      if (comp > baseline) begin
        baseline = comp;
        r.save_baseline = 1'b1;
      end
      if (full_flag) begin
        r.percent = 7'd100;
      end else begin
        if (comp > peak_mv) begin
          nb = bar_level(comp);
          peak_mv = comp;
          if (nb > base_lvl) begin
            base_lvl = nb;
            shown_lvl = nb;
          end
        end
        if (comp >= full_mv) begin
          full_flag = 1'b1;
        end else if (stamp - last_step >= interval_ms) begin
          last_step = stamp;
          shown_lvl = shown_lvl + 3'd1;
          if (shown_lvl > 3'd4) shown_lvl = base_lvl;
        end
        r.percent = {4'd0, shown_lvl} * 7'd25;
      end
      check_mv = comp;
    end else begin
      if (mv < baseline) begin
        baseline = mv;
        r.save_baseline = 1'b1;
      end
      if (was_charging) full_flag = 1'b0;
      lvl = bar_level(baseline);
      r.percent = {4'd0, lvl} * 7'd25;
      check_mv = baseline;
    end
    was_charging = charging;
    r.low_battery = check_mv < low_mv;
    r.baseline_mv = baseline;
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches_o++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    reading_t want;
    if (!rst_ni) begin
      cal_q16      = CAL_RST;
      detect_lvl   = DETECT_RST;
      offset_mv    = {4'd0, OFFSET_RST};
      full_mv      = FULL_RST;
      low_mv       = LOW_RST;
      interval_ms  = {16'd0, INTERVAL_RST};
      init_bl      = BL_RST;
      baseline     = checked_baseline(BL_RST);
      was_charging = 1'b0;
      full_flag    = 1'b0;
      peak_mv      = '0;
      base_lvl     = 3'd1;
      shown_lvl    = 3'd1;
      last_step    = '0;
      expected_readings.delete();
      pending_o    = 0;
      mismatches_o = 0;
      readings_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CAL:      cal_q16 = cfg_data_i[CAL_W-1:0];
          CFG_DETECT:   detect_lvl = cfg_data_i[SENSE_W-1:0];
          CFG_OFFSET:   offset_mv = {4'd0, cfg_data_i[9:0]};
          CFG_FULL:     full_mv = cfg_data_i[MV_W-1:0];
          CFG_LOW:      low_mv = cfg_data_i[MV_W-1:0];
          CFG_INTERVAL: interval_ms = {16'd0, cfg_data_i[15:0]};
          CFG_INIT_BL: begin
            init_bl = cfg_data_i[INIT_BL_W-1:0];
            baseline = checked_baseline(init_bl);
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        readings_o++;
        if (expected_readings.size() == 0) begin
          mismatches_o++;
          $display("%0t ns: unexpected reading, expected none, actual pct %0d bl %0d",
                   $time, percent_i, baseline_out_mv_i);
        end else begin
          want = expected_readings.pop_front();
          check_field("percent", want.percent, percent_i);
          check_field("low_battery", want.low_battery, low_battery_i);
          check_field("save_baseline", want.save_baseline, save_baseline_i);
          check_field("baseline_out_mv", want.baseline_mv, baseline_out_mv_i);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_readings.push_back(gauge_step(battery_code_i, sense_code_i, now_ms_i));
      pending_o = expected_readings.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the battery bar gauge testbench: clock, reset, sample and register
// stimulus with random idling, and the verdict. Depends on bbg_pkg, the
// gauge unit and bbg_gauge_checker.

module testbench import bbg_pkg::*; ();

  localparam int unsigned TOTAL_SAMPLES  = 1800;
  localparam int unsigned PHASE_SAMPLES  = 150;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT    = 1500000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [SENSE_W-1:0]    battery_code_i = '0;
  logic [SENSE_W-1:0]    sense_code_i = '0;
  logic [TS_W-1:0]       now_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PCT_W-1:0]      percent_o;
  logic                  low_battery_o;
  logic                  save_baseline_o;
  logic [MV_W-1:0]       baseline_out_mv_o;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned readings;
  int unsigned samples_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned phases = 0;
  int unsigned cycle_cnt = 0;
  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;
  logic        hold_rx_req = 1'b0;
  logic [31:0] clock_ms = '0;
  int unsigned cur_detect = 1000;
  int unsigned cur_interval = 500;

  battery_bar_gauge_with_charge_animation_unit u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .battery_code_i, .sense_code_i, .now_ms_i,
    .out_valid_o, .out_ready_i, .percent_o, .low_battery_o, .save_baseline_o,
    .baseline_out_mv_o
  );

  bbg_gauge_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .battery_code_i, .sense_code_i, .now_ms_i,
    .out_valid_i(out_valid_o), .out_ready_i, .percent_i(percent_o),
    .low_battery_i(low_battery_o), .save_baseline_i(save_baseline_o),
    .baseline_out_mv_i(baseline_out_mv_o),
    .pending_o(pending), .mismatches_o(mismatches), .readings_o(readings)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d readings outstanding",
               $time, cycle_cnt, pending);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_side
    int g;
    forever begin
      if (hold_rx_req) begin
        out_ready_i = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        hold_rx_req = 1'b0;
      end else if (rx_quiet) begin
        out_ready_i = 1'b1;
        @(negedge clk_i);
      end else begin
        g = idle_len();
        out_ready_i = (g == 0);
        repeat (g == 0 ? $urandom_range(1, 6) : g) @(negedge clk_i);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_writes++;
    if (idx == CFG_DETECT) cur_detect = data & 32'hFFF;
    if (idx == CFG_INTERVAL) cur_interval = data & 32'hFFFF;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_sample(input int unsigned code, input int unsigned sense,
                             input logic [31:0] stamp);
    int g;
    in_valid_i     = 1'b1;
    battery_code_i = code[SENSE_W-1:0];
    sense_code_i   = sense[SENSE_W-1:0];
    now_ms_i       = stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    samples_sent++;
    @(negedge clk_i);
    g = tx_quiet ? 0 : idle_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic pick_config();
    int r;
    r = $urandom_range(0, 7);
    write_reg(CFG_CAL, r == 0 ? 32768 : r == 1 ? 131071 : $urandom_range(32768, 131071));
    r = $urandom_range(0, 9);
    write_reg(CFG_DETECT, r == 0 ? 0 : r == 1 ? 4095 : $urandom_range(300, 3800));
    r = $urandom_range(0, 7);
    write_reg(CFG_OFFSET, r == 0 ? 0 : r == 1 ? 1023 : $urandom_range(0, 400));
    r = $urandom_range(0, 7);
    write_reg(CFG_FULL, r == 0 ? 0 : r == 1 ? 16383 : $urandom_range(3600, 4600));
    r = $urandom_range(0, 7);
    write_reg(CFG_LOW, r == 0 ? 0 : r == 1 ? 16383 : $urandom_range(2800, 3800));
    r = $urandom_range(0, 9);
    write_reg(CFG_INTERVAL, r == 0 ? 0 : r == 1 ? 65535 : r == 2 ? 1 :
              $urandom_range(1, 1500));
    r = $urandom_range(0, 4);
    write_reg(CFG_INIT_BL, r == 0 ? $urandom_range(0, 8191) : $urandom_range(2000, 5000));
  endtask

  task automatic charge_session();
    int n;
    int code_v;
    if ($urandom_range(0, 9) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    n = $urandom_range(1, 5);
    repeat (n) begin
      clock_ms = clock_ms + $urandom_range(0, 2000);
      send_sample($urandom_range(1400, 2800), $urandom_range(0, cur_detect), clock_ms);
    end
    if (cur_detect < 4095) begin
      code_v = $urandom_range(1500, 2500);
      n = $urandom_range(4, 30);
      repeat (n) begin
        code_v = code_v + $urandom_range(0, 40);
        if ($urandom_range(0, 5) == 0) code_v = code_v - $urandom_range(0, 60);
        if (code_v > 4095) code_v = 4095;
        if (code_v < 0) code_v = 0;
        clock_ms = clock_ms + $urandom_range(0, 2 * cur_interval + 1);
        send_sample(code_v, $urandom_range(cur_detect + 1, 4095), clock_ms);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (5) @(negedge clk_i);

    send_sample(0, 0, 0);
    send_sample(4095, 0, 10);
    send_sample(3000, 4095, 100);
    send_sample(2400, 1000, 200);
    send_sample(2000, 1001, 300);
    send_sample(2000, 1001, 800);
    send_sample(2000, 1001, 1300);
    send_sample(2000, 1001, 1800);
    send_sample(2000, 1001, 2300);
    send_sample(2300, 1001, 2400);
    send_sample(2700, 1001, 2500);
    send_sample(2700, 1001, 2600);
    send_sample(1900, 0, 3000);
    send_sample(2000, 2000, 32'hFFFF_FF00);
    send_sample(2000, 2000, 32'h0000_0100);
    settle();

    write_reg(CFG_CAL, 131071);
    write_reg(CFG_DETECT, 0);
    write_reg(CFG_OFFSET, 1023);
    write_reg(CFG_FULL, 16383);
    write_reg(CFG_LOW, 16383);
    write_reg(CFG_INTERVAL, 0);
    write_reg(CFG_INIT_BL, 1999);
    send_sample(4095, 1, 5);
    send_sample(4095, 4095, 5);
    send_sample(4095, 4095, 6);
    send_sample(0, 0, 7);
    settle();

    write_reg(CFG_CAL, 0);
    write_reg(CFG_DETECT, 4095);
    write_reg(CFG_OFFSET, 0);
    write_reg(CFG_FULL, 0);
    write_reg(CFG_LOW, 0);
    write_reg(CFG_INTERVAL, 65535);
    write_reg(CFG_INIT_BL, 5001);
    send_sample(4095, 4095, 0);
    settle();
    write_reg(CFG_SPARE, $urandom_range(0, 131071));
    write_reg(CFG_CAL, 32768);
    write_reg(CFG_DETECT, 0);
    write_reg(CFG_INIT_BL, 5000);
    send_sample(100, 4095, 1);
    send_sample(0, 4095, 2);
    settle();
    write_reg(CFG_INIT_BL, 8191);
    write_reg(CFG_INIT_BL, 2000);

    while (samples_sent < TOTAL_SAMPLES) begin
      settle();
      pick_config();
      phases++;
      tx_quiet = (phases == 2) || ($urandom_range(0, 5) == 0);
      rx_quiet = (phases == 2) || ($urandom_range(0, 5) == 0);
      if (phases == 1) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        hold_rx_req = 1'b1;
      end
      phase_end = samples_sent + PHASE_SAMPLES;
      while (samples_sent < phase_end) begin
        if ($urandom_range(0, 9) < 8) charge_session();
        else send_sample($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom());
      end
    end

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Summary: %0d samples, %0d readings checked, %0d register writes, %0d phases",
             samples_sent, readings, cfg_writes, phases);
    if (pending != 0) $display("%0t ns: %0d readings never arrived", $time, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
